FILE: src/bsft_pkg.sv
// ----------------------------------------------------------------------------
// bsft_pkg
// Shared types and constants of the byte-stuffing frame transmitter.
// ----------------------------------------------------------------------------
package bsft_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] control_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
    } t_out_item;

    // classified job handed from front to back through the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] control_byte;
        logic [7:0] bcc2;
        logic       first_byte;
        logic       last_byte;
    } t_job;

    // configuration register set
    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
        logic [7:0] flag_hide_value;
        logic [7:0] escape_hide_value;
        logic [7:0] address_value;
    } t_cfg;

    // register indexes
    localparam logic [2:0] REG_FLAG        = 3'd0;
    localparam logic [2:0] REG_ESCAPE      = 3'd1;
    localparam logic [2:0] REG_FLAG_HIDE   = 3'd2;
    localparam logic [2:0] REG_ESCAPE_HIDE = 3'd3;
    localparam logic [2:0] REG_ADDRESS     = 3'd4;

    // register reset values
    localparam logic [7:0] RST_FLAG        = 8'h7E;
    localparam logic [7:0] RST_ESCAPE      = 8'h7D;
    localparam logic [7:0] RST_FLAG_HIDE   = 8'h5E;
    localparam logic [7:0] RST_ESCAPE_HIDE = 8'h5D;
    localparam logic [7:0] RST_ADDRESS     = 8'h03;

endpackage

FILE: src/bsft_front.sv
// ----------------------------------------------------------------------------
// bsft_front
// Accepts payload transactions, keeps the running payload XOR and pushes a
// classified job (marks, control byte, BCC2) into the queue.
// ----------------------------------------------------------------------------
module bsft_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bsft_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output bsft_pkg::t_job    o_job
);

    logic [7:0] r_parity;
    logic [7:0] n_parity;
    logic [7:0] w_base;
    logic [7:0] w_fold;

    // accept whenever the queue has room
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // parity restarts on a first mark and is cleared after a last mark
    always_comb begin
        w_base   = i_item.first_byte ? 8'h00 : r_parity;
        w_fold   = w_base ^ i_item.data_byte;
        n_parity = i_item.last_byte ? 8'h00 : w_fold;
    end

    // job record
    always_comb begin
        o_job.data_byte    = i_item.data_byte;
        o_job.control_byte = i_item.control_byte;
        o_job.bcc2         = w_fold;
        o_job.first_byte   = i_item.first_byte;
        o_job.last_byte    = i_item.last_byte;
    end

    // parity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 8'h00;
        end else if (o_push) begin
            r_parity <= n_parity;
        end
    end

endmodule

FILE: src/bsft_fifo.sv
// ----------------------------------------------------------------------------
// bsft_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bsft_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsft_pkg::t_job i_job,
    input  logic           i_pop,
    output bsft_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bsft_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/bsft_back.sv
// ----------------------------------------------------------------------------
// bsft_back
// Walks one job through header (first mark), payload and trailer (last mark)
// symbols, stuffs them and emits one registered line byte per unstalled cycle.
// ----------------------------------------------------------------------------
module bsft_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsft_pkg::t_job      i_job,
    input  logic                i_empty,
    input  bsft_pkg::t_cfg      i_cfg,
    input  logic                i_ready,
    output logic                o_pop,
    output logic                o_valid,
    output bsft_pkg::t_out_item o_item
);

    typedef enum logic [2:0] {
        P_OPEN,
        P_ADDR,
        P_CTRL,
        P_BCC1,
        P_DATA,
        P_BCC2,
        P_CLOSE
    } t_phase;

    t_phase              r_phase;
    logic                r_started;
    logic                r_second;
    logic [7:0]          r_hide;
    logic                r_out_valid;
    bsft_pkg::t_out_item r_out;

    t_phase     w_phase;
    t_phase     w_next_phase;
    logic [7:0] w_sym;
    logic       w_can;
    logic       w_fire;
    logic       w_advance;
    logic       w_done;
    logic [7:0] n_byte;
    logic       n_second;
    logic [7:0] n_hide;

    assign w_can   = !r_out_valid || i_ready;
    assign w_fire  = !i_empty && w_can;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_pop   = w_fire && w_done;

    // phase of the current job and the symbol it stands for
    always_comb begin
        if (r_started) begin
            w_phase = r_phase;
        end else begin
            w_phase = i_job.first_byte ? P_OPEN : P_DATA;
        end
        case (w_phase)
            P_ADDR:  w_sym = i_cfg.address_value;
            P_CTRL:  w_sym = i_job.control_byte;
            P_BCC1:  w_sym = i_cfg.address_value ^ i_job.control_byte;
            P_DATA:  w_sym = i_job.data_byte;
            P_BCC2:  w_sym = i_job.bcc2;
            default: w_sym = i_cfg.flag_value;
        endcase
        case (w_phase)
            P_OPEN:  w_next_phase = P_ADDR;
            P_ADDR:  w_next_phase = P_CTRL;
            P_CTRL:  w_next_phase = P_BCC1;
            P_BCC1:  w_next_phase = P_DATA;
            P_DATA:  w_next_phase = P_BCC2;
            P_BCC2:  w_next_phase = P_CLOSE;
            default: w_next_phase = P_OPEN;
        endcase
    end

    // stuffing: flag rule first, then escape rule
    always_comb begin
        n_second  = 1'b0;
        n_hide    = r_hide;
        w_advance = 1'b1;
        if (r_second) begin
            n_byte = r_hide;
        end else if (w_phase == P_OPEN || w_phase == P_CLOSE) begin
            n_byte = i_cfg.flag_value;
        end else if (w_sym == i_cfg.flag_value) begin
            n_byte    = i_cfg.escape_value;
            n_second  = 1'b1;
            n_hide    = i_cfg.flag_hide_value;
            w_advance = 1'b0;
        end else if (w_sym == i_cfg.escape_value) begin
            n_byte    = i_cfg.escape_value;
            n_second  = 1'b1;
            n_hide    = i_cfg.escape_hide_value;
            w_advance = 1'b0;
        end else begin
            n_byte = w_sym;
        end
        w_done = w_advance &&
                 (w_phase == P_CLOSE || (w_phase == P_DATA && !i_job.last_byte));
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid     <= 1'b1;
            r_out.out_byte  <= n_byte;
            r_out.run_end   <= w_done;
            r_out.frame_end <= (w_phase == P_CLOSE);
            r_second        <= n_second;
            r_hide          <= n_hide;
            if (w_done) begin
                r_started <= 1'b0;
            end else begin
                r_started <= 1'b1;
                r_phase   <= w_advance ? w_next_phase : w_phase;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: src/byte_stuffing_frame_transmitter.sv
// ----------------------------------------------------------------------------
// byte_stuffing_frame_transmitter
// HDLC-like framer: header with XOR check, stuffed payload, XOR trailer.
// ----------------------------------------------------------------------------
// The first line byte of a transaction passes through the job queue and the
// back output register before it is valid on the output.
// The back sequencer emits one line byte per cycle while a job is queued and
// the receiver is ready; an input transaction puts 1 to 2 line bytes on the
// line alone, up to 12 with header and trailer. The job queue lets input be
// taken while earlier transactions are emitted. Reset (synchronous, active
// low) empties the queue, clears parity and loads the register defaults.
module byte_stuffing_frame_transmitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bsft_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bsft_pkg::t_out_item o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    bsft_pkg::t_cfg r_cfg;
    bsft_pkg::t_job w_push_job;
    bsft_pkg::t_job w_head_job;
    logic           w_push;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;
    logic [2:0]     w_index;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value        <= bsft_pkg::RST_FLAG;
            r_cfg.escape_value      <= bsft_pkg::RST_ESCAPE;
            r_cfg.flag_hide_value   <= bsft_pkg::RST_FLAG_HIDE;
            r_cfg.escape_hide_value <= bsft_pkg::RST_ESCAPE_HIDE;
            r_cfg.address_value     <= bsft_pkg::RST_ADDRESS;
        end else if (psel && penable && pwrite) begin
            case (w_index)
                bsft_pkg::REG_FLAG:        r_cfg.flag_value        <= pwdata[7:0];
                bsft_pkg::REG_ESCAPE:      r_cfg.escape_value      <= pwdata[7:0];
                bsft_pkg::REG_FLAG_HIDE:   r_cfg.flag_hide_value   <= pwdata[7:0];
                bsft_pkg::REG_ESCAPE_HIDE: r_cfg.escape_hide_value <= pwdata[7:0];
                bsft_pkg::REG_ADDRESS:     r_cfg.address_value     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_index)
            bsft_pkg::REG_FLAG:        prdata = {24'h0, r_cfg.flag_value};
            bsft_pkg::REG_ESCAPE:      prdata = {24'h0, r_cfg.escape_value};
            bsft_pkg::REG_FLAG_HIDE:   prdata = {24'h0, r_cfg.flag_hide_value};
            bsft_pkg::REG_ESCAPE_HIDE: prdata = {24'h0, r_cfg.escape_hide_value};
            bsft_pkg::REG_ADDRESS:     prdata = {24'h0, r_cfg.address_value};
            default:                   prdata = 32'h0;
        endcase
    end

    // front: accept and classify
    bsft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_data),
        .i_full  (w_full),
        .o_ready (o_ready),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    // job queue
    bsft_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // back: stuff and emit
    bsft_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_head_job),
        .i_empty (w_empty),
        .i_cfg   (r_cfg),
        .i_ready (i_ready),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_item  (o_data)
    );

endmodule

FILE: tb/byte_stuffing_frame_transmitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_frame_transmitter_tb
// Drives payload bytes with first/last marks into the framer and checks every
// line byte against an in-bench frame builder: header, stuffing, block checks
// and closing flag. A short scripted part runs first, then random frames under
// several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_transmitter_tb;

    localparam int         N_SCRIPT    = 14;
    localparam int         PHASE_ITEMS = 32;
    localparam int         STALL_LIMIT = 2000;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    // one scripted row; typed line bytes are packed first byte on top
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  ctrl;
        logic        first;
        logic        last;
        logic [3:0]  n_typed;
        logic [63:0] typed;
    } t_script_row;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    bsft_pkg::t_in_item  i_data  = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    bsft_pkg::t_out_item o_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [4:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // model of the register file and the running payload check
    logic [7:0]  line_cfg [5];
    logic [7:0]  frame_parity;

    // line bytes produced by one transaction, then the queue of bytes due
    bsft_pkg::t_out_item burst_buf [12];
    int                  burst_len;
    bsft_pkg::t_out_item line_bytes_due [$];
    bsft_pkg::t_out_item line_want;

    t_script_row script [N_SCRIPT];
    int          fail_count   = 0;
    int          rx_stall_pct = 0;
    int          quiet_cycles = 0;

    byte_stuffing_frame_transmitter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // line byte checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (line_bytes_due.size() == 0) begin
                $display("%0t: unexpected line byte, expected none got %02h",
                         $time, o_data.out_byte);
                fail_count++;
            end else begin
                line_want = line_bytes_due.pop_front();
                if (o_data.out_byte !== line_want.out_byte) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, line_want.out_byte, o_data.out_byte);
                    fail_count++;
                end
                if (o_data.run_end !== line_want.run_end) begin
                    $display("%0t: run_end expected %b got %b",
                             $time, line_want.run_end, o_data.run_end);
                    fail_count++;
                end
                if (o_data.frame_end !== line_want.frame_end) begin
                    $display("%0t: frame_end expected %b got %b",
                             $time, line_want.frame_end, o_data.frame_end);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles, %0d bytes due",
                     $time, quiet_cycles, line_bytes_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // line byte sent as is
    task automatic push_plain(input logic [7:0] b, input logic closing);
        burst_buf[burst_len] = {b, 1'b0, closing};
        burst_len++;
    endtask

    // line byte between the flags, escaped when it collides with flag or escape
    task automatic push_stuffed(input logic [7:0] b);
        if (b == line_cfg[bsft_pkg::REG_FLAG]) begin
            push_plain(line_cfg[bsft_pkg::REG_ESCAPE], 1'b0);
            push_plain(line_cfg[bsft_pkg::REG_FLAG_HIDE], 1'b0);
        end else if (b == line_cfg[bsft_pkg::REG_ESCAPE]) begin
            push_plain(line_cfg[bsft_pkg::REG_ESCAPE], 1'b0);
            push_plain(line_cfg[bsft_pkg::REG_ESCAPE_HIDE], 1'b0);
        end else begin
            push_plain(b, 1'b0);
        end
    endtask

    // bytes a payload transaction puts on the line
    task automatic frame_line_bytes(input bsft_pkg::t_in_item it);
        burst_len = 0;
        if (it.first_byte) begin
            frame_parity = 8'h00;
            push_plain(line_cfg[bsft_pkg::REG_FLAG], 1'b0);
            push_stuffed(line_cfg[bsft_pkg::REG_ADDRESS]);
            push_stuffed(it.control_byte);
            push_stuffed(line_cfg[bsft_pkg::REG_ADDRESS] ^ it.control_byte);
        end
        push_stuffed(it.data_byte);
        frame_parity = frame_parity ^ it.data_byte;
        if (it.last_byte) begin
            push_stuffed(frame_parity);
            push_plain(line_cfg[bsft_pkg::REG_FLAG], 1'b1);
            frame_parity = 8'h00;
        end
    endtask

    // one input transaction; typed bytes, if given, replace the predicted ones
    task automatic send_item(input bsft_pkg::t_in_item it, input int tx_idle,
                             input int n_typed, input logic [63:0] typed);
        bsft_pkg::t_out_item beat;
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        frame_line_bytes(it);
        if (n_typed != 0) begin
            burst_len = n_typed;
            for (int k = 0; k < n_typed; k++)
                burst_buf[k] = {typed[63 - 8 * k -: 8], 1'b0,
                                it.last_byte && (k == n_typed - 1)};
        end
        for (int k = 0; k < burst_len; k++) begin
            beat         = burst_buf[k];
            beat.run_end = (k == burst_len - 1);
            line_bytes_due.push_back(beat);
        end
    endtask

    // apb write, setup then access
    task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
        logic [23:0] junk;
        junk = 24'($urandom());
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // apb read, compared with the register model
    task automatic reg_read_check(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'h0, val}) begin
            $display("%0t: register %0d read expected %08h got %08h",
                     $time, idx, {24'h0, val}, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new register set, written only once the line has drained
    task automatic configure(input logic [7:0] flag, input logic [7:0] esc,
                             input logic [7:0] fhide, input logic [7:0] ehide,
                             input logic [7:0] addr);
        logic [7:0] vals [5];
        vals[bsft_pkg::REG_FLAG]        = flag;
        vals[bsft_pkg::REG_ESCAPE]      = esc;
        vals[bsft_pkg::REG_FLAG_HIDE]   = fhide;
        vals[bsft_pkg::REG_ESCAPE_HIDE] = ehide;
        vals[bsft_pkg::REG_ADDRESS]     = addr;
        while (line_bytes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        for (int r = bsft_pkg::REG_FLAG; r <= bsft_pkg::REG_ADDRESS; r++) begin
            reg_write(3'(r), vals[r]);
            line_cfg[r] = vals[r];
            reg_read_check(3'(r), vals[r]);
        end
    endtask

    // payload byte biased toward the stuffing and check collisions
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return line_cfg[bsft_pkg::REG_FLAG];
            1:       return line_cfg[bsft_pkg::REG_ESCAPE];
            2:       return line_cfg[bsft_pkg::REG_FLAG] ^ line_cfg[bsft_pkg::REG_ADDRESS];
            3:       return line_cfg[bsft_pkg::REG_ESCAPE] ^ line_cfg[bsft_pkg::REG_ADDRESS];
            4:       return line_cfg[bsft_pkg::REG_FLAG_HIDE];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random frames with some loose and broken transactions mixed in
    task automatic run_traffic(input int n_items, input int tx_idle,
                               input int rx_stall, input int pause_at);
        bsft_pkg::t_in_item it;
        int                 sent;
        int                 frame_len;
        int                 frame_left;
        rx_stall_pct = rx_stall;
        sent       = 0;
        frame_len  = 0;
        frame_left = 0;
        while (sent < n_items) begin
            if (frame_left == 0 && $urandom_range(0, 7) == 0) begin
                it.data_byte    = pick_byte();
                it.control_byte = 8'($urandom_range(0, 255));
                it.first_byte   = 1'($urandom_range(0, 1));
                it.last_byte    = 1'($urandom_range(0, 1));
            end else begin
                if (frame_left == 0) begin
                    frame_len  = $urandom_range(1, 5);
                    frame_left = frame_len;
                end
                it.data_byte    = pick_byte();
                it.control_byte = pick_byte();
                it.first_byte   = (frame_left == frame_len);
                it.last_byte    = (frame_left == 1);
                frame_left--;
            end
            send_item(it, tx_idle, 0, '0);
            sent++;
            // sender holds off until the line has drained
            if (sent == pause_at) begin
                i_valid <= 1'b0;
                while (line_bytes_due.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        bsft_pkg::t_in_item it;

        line_cfg[bsft_pkg::REG_FLAG]        = bsft_pkg::RST_FLAG;
        line_cfg[bsft_pkg::REG_ESCAPE]      = bsft_pkg::RST_ESCAPE;
        line_cfg[bsft_pkg::REG_FLAG_HIDE]   = bsft_pkg::RST_FLAG_HIDE;
        line_cfg[bsft_pkg::REG_ESCAPE_HIDE] = bsft_pkg::RST_ESCAPE_HIDE;
        line_cfg[bsft_pkg::REG_ADDRESS]     = bsft_pkg::RST_ADDRESS;
        frame_parity                        = 8'h00;

        // data, ctrl, first, last, typed count, typed line bytes
        // one-byte frame of zeros under reset registers
        script[0]  = {8'h00, 8'h00, 1'b1, 1'b1, 4'd7, 64'h7E03_0003_0000_7E00};
        // all ones in control and data, frame left open
        script[1]  = {8'hFF, 8'hFF, 1'b1, 1'b0, 4'd0, 64'h0};
        // flag and escape in the payload
        script[2]  = {8'h7E, 8'h00, 1'b0, 1'b0, 4'd2, 64'h7D5E_0000_0000_0000};
        script[3]  = {8'h7D, 8'h00, 1'b0, 1'b0, 4'd2, 64'h7D5D_0000_0000_0000};
        // control ignored without first mark
        script[4]  = {8'h00, 8'hFF, 1'b0, 1'b0, 4'd1, 64'h0000_0000_0000_0000};
        // hide byte alone passes through
        script[5]  = {8'h5E, 8'h00, 1'b0, 1'b0, 4'd1, 64'h5E00_0000_0000_0000};
        script[6]  = {8'hFF, 8'h00, 1'b0, 1'b1, 4'd0, 64'h0};
        // continuation byte outside any frame
        script[7]  = {8'h55, 8'hAA, 1'b0, 1'b0, 4'd1, 64'h5500_0000_0000_0000};
        script[8]  = {8'hA5, 8'h00, 1'b0, 1'b1, 4'd0, 64'h0};
        // control equal to flag, header check equal to escape
        script[9]  = {8'h7D, 8'h7E, 1'b1, 1'b0, 4'd0, 64'h0};
        // open frame abandoned by a new first mark
        script[10] = {8'h81, 8'h7D, 1'b1, 1'b1, 4'd0, 64'h0};
        // payload check lands on the flag
        script[11] = {8'h7E, 8'h7D, 1'b1, 1'b1, 4'd0, 64'h0};
        script[12] = {8'h01, 8'h80, 1'b1, 1'b0, 4'd0, 64'h0};
        script[13] = {8'h80, 8'h01, 1'b0, 1'b1, 4'd0, 64'h0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // scripted part under reset registers
        for (int r = 0; r < N_SCRIPT; r++) begin
            it = {script[r].data, script[r].ctrl, script[r].first, script[r].last};
            send_item(it, 0, script[r].n_typed, script[r].typed);
        end
        i_valid <= 1'b0;

        // low extremes, no idling
        configure(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00);
        run_traffic(PHASE_ITEMS, 0, 0, 0);

        // high extremes, sender idle half the time, one drain pause
        configure(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
        run_traffic(PHASE_ITEMS, 50, 0, 12);

        // flag equal to escape, address on the flag, receiver stalling
        configure(bsft_pkg::RST_FLAG, bsft_pkg::RST_FLAG, bsft_pkg::RST_FLAG_HIDE,
                  bsft_pkg::RST_ESCAPE_HIDE, bsft_pkg::RST_FLAG);
        run_traffic(PHASE_ITEMS, 0, 50, 0);

        // random registers, write beyond the last register must be ignored
        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        reg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
        for (int r = bsft_pkg::REG_FLAG; r <= bsft_pkg::REG_ADDRESS; r++)
            reg_read_check(3'(r), line_cfg[r]);
        run_traffic(PHASE_ITEMS, 23, 23, 0);

        // reset stuffing bytes with address on the flag, longest headers
        configure(bsft_pkg::RST_FLAG, bsft_pkg::RST_ESCAPE, bsft_pkg::RST_FLAG_HIDE,
                  bsft_pkg::RST_ESCAPE_HIDE, bsft_pkg::RST_FLAG);
        run_traffic(PHASE_ITEMS, 0, 0, 0);

        // drain and settle
        while (line_bytes_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
